// ===== sv/brins_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brins_pkg
// Shared types, register indexes and mask tables for the bit range insert core.
// ----------------------------------------------------------------------------
package brins_pkg;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 3;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_BIT_OFFSET = 1'b0;
  localparam logic [IDX_W-1:0] REG_BIT_COUNT  = 1'b1;

  // Destination bits ahead of the run, by start offset.
  localparam logic [BYTE_W-1:0] KEEP_LEAD [8] = '{
    8'h00, 8'h80, 8'hc0, 8'he0, 8'hf0, 8'hf8, 8'hfc, 8'hfe
  };

  // Destination bits after the run, by bit index of the run's final bit.
  localparam logic [BYTE_W-1:0] KEEP_TRAIL [8] = '{
    8'h7f, 8'h3f, 8'h1f, 8'h0f, 8'h07, 8'h03, 8'h01, 8'h00
  };

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] tail_sel;
    logic             cnt_zero;
    logic             first;
    logic             last;
  } merge_ctrl_t;

endpackage

// ===== sv/brins_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brins_cfg
// Configuration registers plus values derived from them at write time.
// ----------------------------------------------------------------------------
module brins_cfg #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brins_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [COUNT_WIDTH-1:0]        cfg_data,
  output logic [brins_pkg::OFF_W-1:0]   off,
  output logic [brins_pkg::OFF_W-1:0]   tail_sel,
  output logic                          cnt_zero,
  output logic [COUNT_WIDTH-3:0]        last_idx
);

  localparam int POS_W = COUNT_WIDTH - 2;

  logic [brins_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [COUNT_WIDTH-1:0]      cnt_r, cnt_nxt;
  logic [brins_pkg::OFF_W-1:0] tail_r, tail_nxt;
  logic                        zero_r, zero_nxt;
  logic [POS_W-1:0]            last_r, last_nxt;
  logic [COUNT_WIDTH:0]        span;
  logic [COUNT_WIDTH:0]        span_m1;

  always_comb begin
    off_nxt = off_r;
    cnt_nxt = cnt_r;
    if (cfg_we) begin
      case (cfg_idx)
        brins_pkg::REG_BIT_OFFSET: off_nxt = cfg_data[brins_pkg::OFF_W-1:0];
        brins_pkg::REG_BIT_COUNT:  cnt_nxt = cfg_data;
        default: ;
      endcase
    end
    span     = {1'b0, cnt_nxt} + (COUNT_WIDTH+1)'(off_nxt);
    span_m1  = span - (COUNT_WIDTH+1)'(1);
    tail_nxt = span_m1[brins_pkg::OFF_W-1:0];
    zero_nxt = (cnt_nxt == '0);
    // index of the final byte: (span - 1) / 8, or 0 for an empty span
    last_nxt = (span == '0) ? '0 : span_m1[COUNT_WIDTH:3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      cnt_r  <= '0;
      tail_r <= '1;
      zero_r <= 1'b1;
      last_r <= '0;
    end else begin
      off_r  <= off_nxt;
      cnt_r  <= cnt_nxt;
      tail_r <= tail_nxt;
      zero_r <= zero_nxt;
      last_r <= last_nxt;
    end
  end

  assign off      = off_r;
  assign tail_sel = tail_r;
  assign cnt_zero = zero_r;
  assign last_idx = last_r;

endmodule

// ===== sv/brins_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brins_merge
// Shift and mask merge of source bits into one destination byte.
// ----------------------------------------------------------------------------
module brins_merge (
  input  brins_pkg::merge_ctrl_t          ctrl,
  input  logic [brins_pkg::BYTE_W-1:0]    prev_src,
  input  logic [brins_pkg::BYTE_W-1:0]    src,
  input  logic [brins_pkg::BYTE_W-1:0]    dst,
  output logic [brins_pkg::BYTE_W-1:0]    merged
);

  logic [2*brins_pkg::BYTE_W-1:0] pair_sh;
  logic [brins_pkg::BYTE_W-1:0]   body;
  logic [brins_pkg::BYTE_W-1:0]   lead;
  logic [brins_pkg::BYTE_W-1:0]   tail;

  always_comb begin
    // low byte holds (prev << (8 - off)) | (src >> off)
    pair_sh = {prev_src, src} >> ctrl.off;
    lead    = brins_pkg::KEEP_LEAD[ctrl.off];
    tail    = brins_pkg::KEEP_TRAIL[ctrl.tail_sel];
    if (ctrl.first) begin
      body = (dst & lead) | (src >> ctrl.off);
    end else begin
      body = pair_sh[brins_pkg::BYTE_W-1:0];
    end
    if (ctrl.last) begin
      body = (body & ~tail) | (dst & tail);
    end
    if (ctrl.cnt_zero) begin
      merged = (ctrl.off == '0) ? '0 : dst;
    end else begin
      merged = body;
    end
  end

endmodule

// ===== sv/bit_range_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_range_insert_core
// Merges a left-aligned source bit run into a destination byte row, one byte
// per transfer, starting at a configurable bit offset.
// ----------------------------------------------------------------------------
// Output: the merged result of an input transfer is registered and shown on the next cycle.
// Throughput: one byte per cycle; the output register takes a new result
// whenever it is empty or being drained in the same cycle.
// Reset: byte position, previous source byte and output valid clear; offset
// and count return to zero. A configuration write restarts the operation.
module bit_range_insert_core #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [7:0] source_byte, [15:8] dest_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] merged_byte
  output logic                        out_tlast,  // last_byte
  input  logic                        cfg_we,
  input  logic [brins_pkg::IDX_W-1:0] cfg_idx,
  input  logic [COUNT_WIDTH-1:0]      cfg_data
);

  localparam int POS_W = COUNT_WIDTH - 2;

  logic [brins_pkg::OFF_W-1:0] cfg_off;
  logic [brins_pkg::OFF_W-1:0] cfg_tail;
  logic                        cfg_zero;
  logic [POS_W-1:0]            cfg_last_idx;

  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [brins_pkg::BYTE_W-1:0] prev_r, prev_nxt;
  logic                        vld_r, vld_nxt;
  logic [brins_pkg::BYTE_W-1:0] data_r;
  logic                        last_r;

  logic                        acc;
  logic                        is_last;
  brins_pkg::merge_ctrl_t      ctrl;
  logic [brins_pkg::BYTE_W-1:0] merged;

  brins_cfg #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .off      (cfg_off),
    .tail_sel (cfg_tail),
    .cnt_zero (cfg_zero),
    .last_idx (cfg_last_idx)
  );

  assign in_tready = !vld_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_last   = cfg_zero || (pos_r == cfg_last_idx);

  always_comb begin
    ctrl.off      = cfg_off;
    ctrl.tail_sel = cfg_tail;
    ctrl.cnt_zero = cfg_zero;
    ctrl.first    = (pos_r == '0);
    ctrl.last     = is_last;
  end

  brins_merge u_merge (
    .ctrl     (ctrl),
    .prev_src (prev_r),
    .src      (in_tdata[7:0]),
    .dst      (in_tdata[15:8]),
    .merged   (merged)
  );

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    if (cfg_we) begin
      pos_nxt  = '0;
      prev_nxt = '0;
    end else if (acc) begin
      // drop back to the first byte once the operation ends
      pos_nxt  = is_last ? '0 : pos_r + POS_W'(1);
      prev_nxt = is_last ? '0 : in_tdata[7:0];
    end
    vld_nxt = acc || (vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      data_r <= merged;
      last_r <= is_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= cfg_last_idx)
    else $error("byte position ran past the final byte");

  a_zero_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cfg_zero && !cfg_we |=> out_tvalid && out_tlast)
    else $error("zero count transfer did not end the operation");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_last |=> pos_r == '0 && prev_r == '0)
    else $error("operation state not cleared after final byte");

  a_mid_advances: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_last && !cfg_we |=> pos_r == $past(pos_r) + POS_W'(1))
    else $error("byte position did not advance");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bit_range_insert_core. A scoreboard predicts every
// merged byte and its last flag from the source/destination pairs that enter
// the core and the offset/count that are programmed. Directed cases cover
// zero counts, one-byte runs, the widest offset and count, and abandoned
// operations; random phases run whole and unfinished operations with random content under
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW         = 20;
  localparam int STALL_MAX  = 4000;
  localparam int ITEM_GOAL  = 1350;

  typedef struct packed {
    logic [7:0] merged;
    logic       last;
  } merged_t;

  class merged_byte_board_t;
    logic [2:0]    offset;
    logic [CW-1:0] count;
    logic [17:0]   pos;
    logic [7:0]    prev_src;
    merged_t       merged_q[$];
    int            failures;

    function new();
      offset   = '0;
      count    = '0;
      pos      = '0;
      prev_src = '0;
      failures = 0;
    endfunction

    function void configure(logic [brins_pkg::IDX_W-1:0] idx, logic [CW-1:0] val);
      if (idx == brins_pkg::REG_BIT_OFFSET) begin
        offset = val[2:0];
      end else begin
        count = val;
      end
      pos      = '0;
      prev_src = '0;
    endfunction

    // Predict the merged byte for one accepted source/destination pair.
    function void take_source(logic [7:0] src, logic [7:0] dst);
      int         span;
      int         total;
      logic [7:0] lead;
      logic [7:0] tail;
      logic [7:0] body;
      merged_t    e;
      span  = int'(offset) + int'(count);
      total = (span + 7) / 8;
      if (total == 0) total = 1;
      e.last = (int'(pos) + 1 >= total);
      if (count == 0) begin
        e.merged = (offset == 0) ? 8'h00 : dst;
        e.last   = 1'b1;
      end else begin
        lead = ~(8'hff >> offset);
        if (pos == 0) begin
          body = (dst & lead) | (src >> offset);
        end else begin
          body = 8'({prev_src, src} >> offset);
        end
        if (e.last) begin
          // keep destination bits below the final run bit
          tail = 8'(8'hff >> (((span - 1) % 8) + 1));
          body = (body & ~tail) | (dst & tail);
        end
        e.merged = body;
      end
      merged_q.push_back(e);
      if (e.last) begin
        pos      = '0;
        prev_src = '0;
      end else begin
        pos      = pos + 1'b1;
        prev_src = src;
      end
    endfunction

    function void check_merged(logic [7:0] merged, logic last);
      merged_t e;
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected result merged=%02h last=%0b", $time, merged, last);
        failures++;
        return;
      end
      e = merged_q.pop_front();
      if (merged !== e.merged) begin
        $display("%0t: merged_byte expected %02h actual %02h", $time, e.merged, merged);
        failures++;
      end
      if (last !== e.last) begin
        $display("%0t: last_byte expected %0b actual %0b", $time, e.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return merged_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;
  logic                          out_tlast;
  logic                          cfg_we = 1'b0;
  logic [brins_pkg::IDX_W-1:0]   cfg_idx = brins_pkg::REG_BIT_OFFSET;
  logic [CW-1:0]                 cfg_data = '0;

  merged_byte_board_t sb;
  int send_idle = 21;
  int recv_idle = 58;
  int sent = 0;
  int stall = 0;

  always #4 clk = ~clk;

  bit_range_insert_core #(.COUNT_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] source_byte, [15:8] dest_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] merged_byte
    .out_tlast (out_tlast),  // last_byte
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_merged(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall <= 0;
    end else if (stall >= STALL_MAX) begin
      $display("[bit_range_insert_core] ERROR");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  function automatic int span_bytes(logic [2:0] off, logic [CW-1:0] cnt);
    int n;
    n = (int'(off) + int'(cnt) + 7) / 8;
    return (n == 0) ? 1 : n;
  endfunction

  task automatic send_byte(input logic [7:0] src, input logic [7:0] dst);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dst, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_source(src, dst);
    sent++;
    if (sent < ITEM_GOAL / 3) begin
      send_idle = 21;
      recv_idle = 58;
    end else if (sent < 2 * ITEM_GOAL / 3) begin
      send_idle = 58;
      recv_idle = 21;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  // Drop valid and hold until every predicted byte has been transferred.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] off, input logic [CW-1:0] cnt,
                            input logic [CW-4:0] junk);
    cfg_we   <= 1'b1;
    cfg_idx  <= brins_pkg::REG_BIT_OFFSET;
    cfg_data <= {junk, off};
    sb.configure(brins_pkg::REG_BIT_OFFSET, {junk, off});
    @(posedge clk);
    cfg_idx  <= brins_pkg::REG_BIT_COUNT;
    cfg_data <= cnt;
    sb.configure(brins_pkg::REG_BIT_COUNT, cnt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [2:0] off, input logic [CW-1:0] cnt, input int n);
    drain();
    set_config(off, cnt, (CW-3)'($urandom));
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), 8'($urandom));
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    int            d_off[9];
    int            d_cnt[9];
    int            d_n[9];
    logic [7:0]    src;
    logic [2:0]    off;
    logic [CW-1:0] cnt;
    int            pick;
    int            n;
    sb = new();
    d_off = '{5, 0, 7, 7, 3, 0, 7, 1, 2};
    d_cnt = '{0, 8, 1, 9, 13, (1 << CW) - 1, (1 << CW) - 1, 20, 6};
    d_n   = '{1, 1, 2, 2, 2, 6, 4, 3, 1};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero offset, zero count
    send_byte(8'hff, 8'hff);
    for (int c = 0; c < 9; c++) begin
      drain();
      set_config(d_off[c][2:0], CW'(d_cnt[c]), (c % 2) ? '1 : '0);
      for (int j = 0; j < d_n[c]; j++) begin
        src = ((j + c) % 2) ? 8'hff : 8'h00;
        send_byte(src, (c % 2) ? src : ~src);
      end
    end

    while (sent < ITEM_GOAL) begin
      off  = 3'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 8) begin
        cnt = '0;
        n   = $urandom_range(1, 8);
      end else if (pick < 14) begin
        cnt = '1;
        n   = $urandom_range(1, 24);
      end else if (pick < 22) begin
        cnt = CW'($urandom);
        n   = $urandom_range(1, 24);
      end else begin
        cnt = CW'($urandom_range(1, 64));
        n   = $urandom_range(1, 5) * span_bytes(off, cnt);
        // sometimes leave an operation unfinished for the next write to abandon
        if ($urandom_range(3) == 0) n += $urandom_range(0, span_bytes(off, cnt) - 1);
      end
      run_phase(off, cnt, n);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[bit_range_insert_core] OK");
    end else begin
      $display("[bit_range_insert_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== bit_range_insert_core.f =====
sv/brins_pkg.sv
sv/brins_cfg.sv
sv/brins_merge.sv
sv/bit_range_insert_core.sv
bench/tb_top.sv
